>>> src/bcr_pkg.sv
package bcr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DW        = 25;

  localparam logic [22:0] RADIUS_RST = 23'd1310720;
  localparam logic [16:0] STEP_RST   = 17'd0;

  localparam logic signed [63:0] FX_RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic [17:0]        ONE_FX = 18'(2 ** FRAC_BITS);

  typedef enum logic [0:0] {
    CFG_BALL_RADIUS = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] vxa;
    logic signed [31:0] vya;
    logic [16:0]        ea;
    logic [22:0]        ma;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic signed [31:0] vxb;
    logic signed [31:0] vyb;
    logic [16:0]        eb;
    logic [22:0]        mb;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] vxa;
    logic signed [31:0] vya;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic signed [31:0] vxb;
    logic signed [31:0] vyb;
    logic               collided;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] vxa;
    logic signed [31:0] vya;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic signed [31:0] vxb;
    logic signed [31:0] vyb;
    logic [16:0]        ea;
    logic [16:0]        eb;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic               hit;
    logic               neg_x;
    logic               neg_y;
  } work_t;

  typedef struct packed {
    logic [3:0][DW-1:0] num;
    logic [DW-1:0]      den_n;
    logic [DW-1:0]      den_m;
  } div_req_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] val;
  } sat_t;

  function automatic logic signed [63:0] tdiv_fx(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v[63] ? v + FX_RND : v;
    return b >>> FRAC_BITS;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.flag = 1'b1;
      r.val  = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r.flag = 1'b1;
      r.val  = 32'sh80000000;
    end else begin
      r.flag = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/bcr_contact.sv
module bcr_contact import bcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_item_t    item_i,
  input  logic [22:0] radius_i,
  output logic        valid_o,
  output work_t       work_o,
  output div_req_t    req_o
);

  typedef struct packed {
    work_t              work;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [23:0]        d;
    logic [22:0]        ma;
    logic [22:0]        mb;
    logic [23:0]        msum;
  } s1_t;

  typedef struct packed {
    work_t              work;
    logic signed [65:0] dx2;
    logic signed [65:0] dy2;
    logic signed [65:0] pdx;
    logic signed [65:0] pdy;
    logic [47:0]        dd;
    logic               box;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic [23:0]        d;
    logic [22:0]        ma;
    logic [22:0]        mb;
    logic [23:0]        msum;
  } s2_t;

  s1_t      s1_d, s1_q;
  s2_t      s2_d, s2_q;
  work_t    w3_d, w3_q;
  div_req_t r3_d, r3_q;
  logic [2:0] v_q;

  always_comb begin
    s1_d.work.xa    = item_i.xa;
    s1_d.work.ya    = item_i.ya;
    s1_d.work.vxa   = item_i.vxa;
    s1_d.work.vya   = item_i.vya;
    s1_d.work.xb    = item_i.xb;
    s1_d.work.yb    = item_i.yb;
    s1_d.work.vxb   = item_i.vxb;
    s1_d.work.vyb   = item_i.vyb;
    s1_d.work.ea    = item_i.ea;
    s1_d.work.eb    = item_i.eb;
    s1_d.work.dvx   = 33'(item_i.vxa) - 33'(item_i.vxb);
    s1_d.work.dvy   = 33'(item_i.vya) - 33'(item_i.vyb);
    s1_d.work.hit   = 1'b0;
    s1_d.work.neg_x = 1'b0;
    s1_d.work.neg_y = 1'b0;
    s1_d.dx         = 33'(item_i.xa) - 33'(item_i.xb);
    s1_d.dy         = 33'(item_i.ya) - 33'(item_i.yb);
    s1_d.d          = {radius_i, 1'b0};
    s1_d.ma         = item_i.ma;
    s1_d.mb         = item_i.mb;
    s1_d.msum       = 24'(item_i.ma) + 24'(item_i.mb);
  end

  always_comb begin
    s2_d.work = s1_q.work;
    s2_d.dx2  = s1_q.dx * s1_q.dx;
    s2_d.dy2  = s1_q.dy * s1_q.dy;
    s2_d.pdx  = s1_q.dx * s1_q.work.dvx;
    s2_d.pdy  = s1_q.dy * s1_q.work.dvy;
    s2_d.dd   = 48'(s1_q.d) * 48'(s1_q.d);
    s2_d.adx  = s1_q.dx[32] ? 33'(-s1_q.dx) : 33'(s1_q.dx);
    s2_d.ady  = s1_q.dy[32] ? 33'(-s1_q.dy) : 33'(s1_q.dy);
    s2_d.box  = (s1_q.d != '0) && (s2_d.adx <= 33'(s1_q.d)) && (s2_d.ady <= 33'(s1_q.d));
    s2_d.d    = s1_q.d;
    s2_d.ma   = s1_q.ma;
    s2_d.mb   = s1_q.mb;
    s2_d.msum = s1_q.msum;
    s2_d.work.neg_x = s1_q.dx[32];
    s2_d.work.neg_y = s1_q.dy[32];
  end

  always_comb begin
    logic signed [66:0] dsq;
    logic signed [66:0] dot;
    dsq  = 67'(s2_q.dx2) + 67'(s2_q.dy2);
    dot  = 67'(s2_q.pdx) + 67'(s2_q.pdy);
    w3_d     = s2_q.work;
    w3_d.hit = s2_q.box && (dsq <= $signed({19'd0, s2_q.dd})) && dot[66];
    r3_d.num[0] = w3_d.hit ? s2_q.adx[DW-1:0] : '0;
    r3_d.num[1] = w3_d.hit ? s2_q.ady[DW-1:0] : '0;
    r3_d.num[2] = DW'(s2_q.ma);
    r3_d.num[3] = DW'(s2_q.mb);
    r3_d.den_n  = DW'(s2_q.d);
    r3_d.den_m  = (s2_q.msum == '0) ? DW'(1) : DW'(s2_q.msum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      w3_q <= w3_d;
      r3_q <= r3_d;
    end
  end

  assign valid_o = v_q[2];
  assign work_o  = w3_q;
  assign req_o   = r3_q;

endmodule

>>> src/bcr_div_pipe.sv
module bcr_div_pipe import bcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  work_t               work_i,
  input  div_req_t            req_i,
  output logic                valid_o,
  output work_t               work_o,
  output logic [3:0][QW-1:0]  quo_o
);

  typedef struct packed {
    logic [3:0][DW-1:0] rem;
    logic [3:0][QW-1:0] quo;
    logic [DW-1:0]      den_n;
    logic [DW-1:0]      den_m;
    work_t              work;
  } div_st_t;

  div_st_t st_in [QW];
  div_st_t st_d  [QW];
  div_st_t st_q  [QW];
  logic [QW-1:0] v_q;

  assign st_in[0] = '{rem: req_i.num, quo: '0, den_n: req_i.den_n,
                      den_m: req_i.den_m, work: work_i};

  for (genvar i = 1; i < QW; i++) begin : g_link
    assign st_in[i] = st_q[i-1];
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    always_comb begin
      logic [DW:0]   cand;
      logic [DW-1:0] den;
      st_d[i] = st_in[i];
      for (int l = 0; l < 4; l++) begin
        den  = (l < 2) ? st_in[i].den_n : st_in[i].den_m;
        cand = (i == 0) ? {1'b0, st_in[i].rem[l]} : {st_in[i].rem[l], 1'b0};
        if (cand >= {1'b0, den}) begin
          st_d[i].rem[l] = DW'(cand - {1'b0, den});
          st_d[i].quo[l] = {st_in[i].quo[l][QW-2:0], 1'b1};
        end else begin
          st_d[i].rem[l] = DW'(cand);
          st_d[i].quo[l] = {st_in[i].quo[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  assign valid_o = v_q[QW-1];
  assign work_o  = st_q[QW-1].work;
  assign quo_o   = st_q[QW-1].quo;

endmodule

>>> src/bcr_response.sv
module bcr_response import bcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  work_t              work_i,
  input  logic [3:0][QW-1:0] quo_i,
  input  logic [16:0]        step_i,
  output logic               valid_o,
  output out_item_t          res_o
);

  typedef struct packed {
    work_t              work;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [16:0]        fa;
    logic [16:0]        fb;
    logic signed [50:0] px;
    logic signed [50:0] py;
  } r1_t;

  typedef struct packed {
    work_t              work;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [16:0]        fa;
    logic [16:0]        fb;
    logic signed [36:0] rel;
  } r2_t;

  typedef struct packed {
    work_t              work;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [54:0] qa;
    logic signed [54:0] qb;
  } r3_t;

  typedef struct packed {
    work_t              work;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [55:0] pa;
    logic signed [55:0] pb;
  } r4_t;

  typedef struct packed {
    work_t              work;
    logic signed [55:0] hxa;
    logic signed [55:0] hya;
    logic signed [55:0] hxb;
    logic signed [55:0] hyb;
  } r5_t;

  typedef struct packed {
    work_t              work;
    logic signed [31:0] nvxa;
    logic signed [31:0] nvya;
    logic signed [31:0] nvxb;
    logic signed [31:0] nvyb;
    logic               sat;
  } r6_t;

  typedef struct packed {
    work_t              work;
    logic signed [31:0] nvxa;
    logic signed [31:0] nvya;
    logic signed [31:0] nvxb;
    logic signed [31:0] nvyb;
    logic signed [49:0] mxa;
    logic signed [49:0] mya;
    logic signed [49:0] mxb;
    logic signed [49:0] myb;
    logic               sat;
  } r7_t;

  r1_t r1_d, r1_q;
  r2_t r2_d, r2_q;
  r3_t r3_d, r3_q;
  r4_t r4_d, r4_q;
  r5_t r5_d, r5_q;
  r6_t r6_d, r6_q;
  r7_t r7_d, r7_q;
  out_item_t r8_d, r8_q;
  logic [7:0] v_q;

  always_comb begin
    logic signed [17:0] mag_x;
    logic signed [17:0] mag_y;
    mag_x     = $signed({1'b0, quo_i[0]});
    mag_y     = $signed({1'b0, quo_i[1]});
    r1_d.work = work_i;
    r1_d.nx   = work_i.neg_x ? -mag_x : mag_x;
    r1_d.ny   = work_i.neg_y ? -mag_y : mag_y;
    r1_d.fa   = quo_i[2];
    r1_d.fb   = quo_i[3];
    r1_d.px   = work_i.dvx * r1_d.nx;
    r1_d.py   = work_i.dvy * r1_d.ny;
  end

  always_comb begin
    logic signed [63:0] rel;
    rel       = tdiv_fx(64'(r1_q.px) + 64'(r1_q.py));
    r2_d.work = r1_q.work;
    r2_d.nx   = r1_q.nx;
    r2_d.ny   = r1_q.ny;
    r2_d.fa   = r1_q.fa;
    r2_d.fb   = r1_q.fb;
    r2_d.rel  = rel[36:0];
  end

  always_comb begin
    r3_d.work = r2_q.work;
    r3_d.nx   = r2_q.nx;
    r3_d.ny   = r2_q.ny;
    r3_d.qa   = r2_q.rel * $signed({1'b0, r2_q.fb});
    r3_d.qb   = r2_q.rel * $signed({1'b0, r2_q.fa});
  end

  always_comb begin
    logic signed [63:0] ta;
    logic signed [63:0] tb;
    logic signed [36:0] sa;
    logic signed [36:0] sb;
    logic [17:0]        ka;
    logic [17:0]        kb;
    ta        = tdiv_fx(64'(r3_q.qa));
    tb        = tdiv_fx(64'(r3_q.qb));
    sa        = ta[36:0];
    sb        = tb[36:0];
    ka        = 18'(r3_q.work.ea) + ONE_FX;
    kb        = 18'(r3_q.work.eb) + ONE_FX;
    r4_d.work = r3_q.work;
    r4_d.nx   = r3_q.nx;
    r4_d.ny   = r3_q.ny;
    r4_d.pa   = sa * $signed({1'b0, ka});
    r4_d.pb   = sb * $signed({1'b0, kb});
  end

  always_comb begin
    logic signed [63:0] ta;
    logic signed [63:0] tb;
    logic signed [37:0] ha;
    logic signed [37:0] hb;
    ta        = tdiv_fx(64'(r4_q.pa));
    tb        = tdiv_fx(64'(r4_q.pb));
    ha        = ta[37:0];
    hb        = tb[37:0];
    r5_d.work = r4_q.work;
    r5_d.hxa  = ha * r4_q.nx;
    r5_d.hya  = ha * r4_q.ny;
    r5_d.hxb  = hb * r4_q.nx;
    r5_d.hyb  = hb * r4_q.ny;
  end

  always_comb begin
    sat_t sxa;
    sat_t sya;
    sat_t sxb;
    sat_t syb;
    sxa       = sat32(64'(r5_q.work.vxa) - tdiv_fx(64'(r5_q.hxa)));
    sya       = sat32(64'(r5_q.work.vya) - tdiv_fx(64'(r5_q.hya)));
    sxb       = sat32(64'(r5_q.work.vxb) + tdiv_fx(64'(r5_q.hxb)));
    syb       = sat32(64'(r5_q.work.vyb) + tdiv_fx(64'(r5_q.hyb)));
    r6_d.work = r5_q.work;
    r6_d.nvxa = sxa.val;
    r6_d.nvya = sya.val;
    r6_d.nvxb = sxb.val;
    r6_d.nvyb = syb.val;
    r6_d.sat  = sxa.flag | sya.flag | sxb.flag | syb.flag;
  end

  always_comb begin
    logic signed [17:0] dt;
    dt        = $signed({1'b0, step_i});
    r7_d.work = r6_q.work;
    r7_d.nvxa = r6_q.nvxa;
    r7_d.nvya = r6_q.nvya;
    r7_d.nvxb = r6_q.nvxb;
    r7_d.nvyb = r6_q.nvyb;
    r7_d.mxa  = r6_q.nvxa * dt;
    r7_d.mya  = r6_q.nvya * dt;
    r7_d.mxb  = r6_q.nvxb * dt;
    r7_d.myb  = r6_q.nvyb * dt;
    r7_d.sat  = r6_q.sat;
  end

  always_comb begin
    sat_t pxa;
    sat_t pya;
    sat_t pxb;
    sat_t pyb;
    pxa = sat32(64'(r7_q.work.xa) + tdiv_fx(64'(r7_q.mxa)));
    pya = sat32(64'(r7_q.work.ya) + tdiv_fx(64'(r7_q.mya)));
    pxb = sat32(64'(r7_q.work.xb) + tdiv_fx(64'(r7_q.mxb)));
    pyb = sat32(64'(r7_q.work.yb) + tdiv_fx(64'(r7_q.myb)));
    if (r7_q.work.hit) begin
      r8_d.xa        = pxa.val;
      r8_d.ya        = pya.val;
      r8_d.vxa       = r7_q.nvxa;
      r8_d.vya       = r7_q.nvya;
      r8_d.xb        = pxb.val;
      r8_d.yb        = pyb.val;
      r8_d.vxb       = r7_q.nvxb;
      r8_d.vyb       = r7_q.nvyb;
      r8_d.collided  = 1'b1;
      r8_d.saturated = r7_q.sat | pxa.flag | pya.flag | pxb.flag | pyb.flag;
    end else begin
      r8_d.xa        = r7_q.work.xa;
      r8_d.ya        = r7_q.work.ya;
      r8_d.vxa       = r7_q.work.vxa;
      r8_d.vya       = r7_q.work.vya;
      r8_d.xb        = r7_q.work.xb;
      r8_d.yb        = r7_q.work.yb;
      r8_d.vxb       = r7_q.work.vxb;
      r8_d.vyb       = r7_q.work.vyb;
      r8_d.collided  = 1'b0;
      r8_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
      r5_q <= r5_d;
      r6_q <= r6_d;
      r7_q <= r7_d;
      r8_q <= r8_d;
    end
  end

  assign valid_o = v_q[7];
  assign res_o   = r8_q;

endmodule

>>> src/ball_pair_collision_response_unit.sv
// Throughput: one ball pair per cycle while no result beat is stalled;
// the 17-stage quotient pipeline makes up most of the depth.
// A stalled result beat holds every stage, so the input stalls in the same cycle.
// Reset: asynchronous, active low; clears all valid bits, radius to 20.0, time step to 0.
module ball_pair_collision_response_unit import bcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_a_i,
  input  logic signed [31:0] pos_y_a_i,
  input  logic signed [31:0] vel_x_a_i,
  input  logic signed [31:0] vel_y_a_i,
  input  logic [16:0]        restitution_a_i,
  input  logic [22:0]        mass_a_i,
  input  logic signed [31:0] pos_x_b_i,
  input  logic signed [31:0] pos_y_b_i,
  input  logic signed [31:0] vel_x_b_i,
  input  logic signed [31:0] vel_y_b_i,
  input  logic [16:0]        restitution_b_i,
  input  logic [22:0]        mass_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_pos_x_a_o,
  output logic signed [31:0] new_pos_y_a_o,
  output logic signed [31:0] new_vel_x_a_o,
  output logic signed [31:0] new_vel_y_a_o,
  output logic signed [31:0] new_pos_x_b_o,
  output logic signed [31:0] new_pos_y_b_o,
  output logic signed [31:0] new_vel_x_b_o,
  output logic signed [31:0] new_vel_y_b_o,
  output logic               collided_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i
);

  logic [22:0] radius_q;
  logic [16:0] step_q;
  logic        en;
  in_item_t    item;
  logic        c_valid;
  work_t       c_work;
  div_req_t    c_req;
  logic        d_valid;
  work_t       d_work;
  logic [3:0][QW-1:0] d_quo;
  logic        r_valid;
  out_item_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      step_q   <= STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BALL_RADIUS: radius_q <= cfg_data_i;
        CFG_TIME_STEP:   step_q   <= cfg_data_i[16:0];
        default:         radius_q <= radius_q;
      endcase
    end
  end

  assign en         = !(r_valid && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    item.xa  = pos_x_a_i;
    item.ya  = pos_y_a_i;
    item.vxa = vel_x_a_i;
    item.vya = vel_y_a_i;
    item.ea  = restitution_a_i;
    item.ma  = mass_a_i;
    item.xb  = pos_x_b_i;
    item.yb  = pos_y_b_i;
    item.vxb = vel_x_b_i;
    item.vyb = vel_y_b_i;
    item.eb  = restitution_b_i;
    item.mb  = mass_b_i;
  end

  bcr_contact u_contact (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .item_i   (item),
    .radius_i (radius_q),
    .valid_o  (c_valid),
    .work_o   (c_work),
    .req_o    (c_req)
  );

  bcr_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .work_i  (c_work),
    .req_i   (c_req),
    .valid_o (d_valid),
    .work_o  (d_work),
    .quo_o   (d_quo)
  );

  bcr_response u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .work_i  (d_work),
    .quo_i   (d_quo),
    .step_i  (step_q),
    .valid_o (r_valid),
    .res_o   (res)
  );

  assign out_valid_o   = r_valid;
  assign new_pos_x_a_o = res.xa;
  assign new_pos_y_a_o = res.ya;
  assign new_vel_x_a_o = res.vxa;
  assign new_vel_y_a_o = res.vya;
  assign new_pos_x_b_o = res.xb;
  assign new_pos_y_b_o = res.yb;
  assign new_vel_x_b_o = res.vxb;
  assign new_vel_y_b_o = res.vyb;
  assign collided_o    = res.collided;
  assign saturated_o   = res.saturated;

`ifndef NO_ASSERTIONS
  a_sat_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !collided_o |-> !saturated_o)
    else $error("saturation flagged without contact");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result beat");

  a_drop_only_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result beat dropped while stalled");
`endif

endmodule
